[rtl/ede_pkg.sv]
`timescale 1ns / 1ps

package ede_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int SYM_W       = 8;
    localparam int DIST_W      = 9;

    localparam logic [DIST_W-1:0] DIST_MAX = 9'd511;

    localparam logic FUNC_A = 1'b0;
    localparam logic FUNC_B = 1'b1;

    // TK_A: A symbol looking for its cell, TK_B: B symbol updating the row,
    // TK_PROBE: B symbol past the length limit, reads the row only,
    // TK_SWEEP: carries the pair tag and retires stale cells.
    typedef enum logic [1:0] {
        TK_A,
        TK_B,
        TK_PROBE,
        TK_SWEEP
    } tok_kind_t;

    typedef struct packed {
        logic             valid;
        tok_kind_t        kind;
        logic             tag;
        logic             last;
        logic             ovf;
        logic [SYM_W-1:0] symbol;
    } ede_tok_t;

endpackage

[rtl/ede_in_if.sv]
`timescale 1ns / 1ps

interface ede_in_if;
    import ede_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output func, output symbol, output last, input ready);
    modport sink   (input valid, input func, input symbol, input last, output ready);
endinterface

[rtl/ede_out_if.sv]
`timescale 1ns / 1ps

interface ede_out_if;
    import ede_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

[rtl/ede_head.sv]
`timescale 1ns / 1ps

module ede_head #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF,
    parameter int DW      = $clog2(MAX_LEN + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    ede_in_if.sink           symbols,
    output ede_pkg::ede_tok_t tok,
    output logic [DW-1:0]    new_val,
    output logic [DW-1:0]    old_val
);
    import ede_pkg::*;

    logic [DW-1:0] a_len_reg, a_len_next;
    logic [DW-1:0] b_cnt_reg, b_cnt_next;
    logic          ovf_reg, ovf_next;
    logic          closed_reg, closed_next;
    logic          tag_reg, tag_next;
    ede_tok_t      tok_reg, tok_next;
    logic [DW-1:0] new_reg, new_next;
    logic [DW-1:0] old_reg, old_next;
    logic          fire;

    assign symbols.ready = en;
    assign fire          = symbols.valid && en;

    always_comb
    begin
        a_len_next  = a_len_reg;
        b_cnt_next  = b_cnt_reg;
        ovf_next    = ovf_reg;
        closed_next = closed_reg;
        tag_next    = tag_reg;
        new_next    = new_reg;
        old_next    = old_reg;
        tok_next        = '0;
        tok_next.kind   = TK_SWEEP;
        tok_next.symbol = symbols.symbol;
        if (fire)
        begin
            tok_next.valid = 1'b1;
            if (symbols.func == FUNC_A)
            begin
                // A symbol after a closed A opens a new pair
                if (closed_reg)
                begin
                    a_len_next  = '0;
                    b_cnt_next  = '0;
                    ovf_next    = 1'b0;
                    closed_next = 1'b0;
                    tag_next    = ~tag_reg;
                end
                if (a_len_next < DW'(MAX_LEN))
                begin
                    tok_next.kind = TK_A;
                    a_len_next    = a_len_next + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                if (symbols.last)
                begin
                    closed_next = 1'b1;
                    b_cnt_next  = '0;
                end
                tok_next.tag = tag_next;
                tok_next.ovf = ovf_next;
            end
            else
            begin
                if (!closed_reg)
                begin
                    closed_next = 1'b1;
                    b_cnt_next  = '0;
                end
                if (b_cnt_next < DW'(MAX_LEN))
                begin
                    tok_next.kind = TK_B;
                    old_next      = b_cnt_next;
                    b_cnt_next    = b_cnt_next + 1'b1;
                    new_next      = b_cnt_next;
                end
                else
                begin
                    ovf_next      = 1'b1;
                    tok_next.kind = TK_PROBE;
                    new_next      = b_cnt_next;
                    old_next      = b_cnt_next;
                end
                tok_next.tag  = tag_reg;
                tok_next.last = symbols.last;
                tok_next.ovf  = ovf_next;
                if (symbols.last)
                begin
                    a_len_next  = '0;
                    b_cnt_next  = '0;
                    ovf_next    = 1'b0;
                    closed_next = 1'b0;
                    tag_next    = ~tag_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_len_reg  <= '0;
            b_cnt_reg  <= '0;
            ovf_reg    <= 1'b0;
            closed_reg <= 1'b0;
            tag_reg    <= 1'b0;
            tok_reg    <= '0;
        end
        else if (en)
        begin
            a_len_reg  <= a_len_next;
            b_cnt_reg  <= b_cnt_next;
            ovf_reg    <= ovf_next;
            closed_reg <= closed_next;
            tag_reg    <= tag_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            new_reg <= new_next;
            old_reg <= old_next;
        end
    end

    assign tok     = tok_reg;
    assign new_val = new_reg;
    assign old_val = old_reg;

endmodule

[rtl/ede_cell.sv]
`timescale 1ns / 1ps

module ede_cell #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF,
    parameter int DW      = $clog2(MAX_LEN + 1),
    parameter int INDEX   = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  ede_pkg::ede_tok_t tok_in,
    input  logic [DW-1:0]     left_new,
    input  logic [DW-1:0]     left_old,
    output ede_pkg::ede_tok_t tok_out,
    output logic [DW-1:0]     out_new,
    output logic [DW-1:0]     out_old
);
    import ede_pkg::*;

    logic             filled_reg, filled_next;
    logic             tag_reg, tag_next;
    logic [SYM_W-1:0] a_sym_reg, a_sym_next;
    logic [DW-1:0]    dp_reg, dp_next;
    ede_tok_t         tok_reg, tok_next;
    logic [DW-1:0]    new_reg, new_next;
    logic [DW-1:0]    old_reg, old_next;
    logic             own;
    logic [DW-1:0]    m_du, m_all, edit_val;

    // cell belongs to the pair of the passing item only if the tags agree
    assign own = filled_reg && (tag_reg == tok_in.tag);

    always_comb
    begin
        m_du     = (left_old < dp_reg) ? left_old : dp_reg;
        m_all    = (m_du < left_new) ? m_du : left_new;
        edit_val = (a_sym_reg == tok_in.symbol) ? left_old : m_all + 1'b1;
    end

    always_comb
    begin
        filled_next = filled_reg;
        tag_next    = tag_reg;
        a_sym_next  = a_sym_reg;
        dp_next     = dp_reg;
        tok_next    = tok_in;
        new_next    = left_new;
        old_next    = left_old;
        if (tok_in.valid)
        begin
            if (tag_reg != tok_in.tag)
            begin
                tag_next    = tok_in.tag;
                filled_next = 1'b0;
            end
            case (tok_in.kind)
                TK_A:
                begin
                    if (!own)
                    begin
                        // first free cell takes the symbol; row starts at its index
                        filled_next   = 1'b1;
                        a_sym_next    = tok_in.symbol;
                        dp_next       = DW'(INDEX);
                        tok_next.kind = TK_SWEEP;
                    end
                end
                TK_B:
                begin
                    if (own)
                    begin
                        dp_next  = edit_val;
                        new_next = edit_val;
                        old_next = dp_reg;
                    end
                end
                TK_PROBE:
                begin
                    if (own)
                    begin
                        new_next = dp_reg;
                        old_next = dp_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            tag_reg    <= 1'b0;
            tok_reg    <= '0;
        end
        else if (en)
        begin
            filled_reg <= filled_next;
            tag_reg    <= tag_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sym_reg <= a_sym_next;
            dp_reg    <= dp_next;
            new_reg   <= new_next;
            old_reg   <= old_next;
        end
    end

    assign tok_out = tok_reg;
    assign out_new = new_reg;
    assign out_old = old_reg;

endmodule

[rtl/ede_tail.sv]
`timescale 1ns / 1ps

module ede_tail #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF,
    parameter int DW      = $clog2(MAX_LEN + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ede_pkg::ede_tok_t tok,
    input  logic [DW-1:0]     new_val,
    output logic              en,
    ede_out_if.source         results
);
    import ede_pkg::*;

    localparam int EW = (DW > DIST_W) ? DW : DIST_W;

    logic              valid_reg, valid_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              ovf_reg, ovf_next;
    logic              is_result;
    logic [EW-1:0]     ext_val;

    assign is_result = tok.valid && tok.last && ((tok.kind == TK_B) || (tok.kind == TK_PROBE));
    assign ext_val   = EW'(new_val);

    // chain halts only when a result meets a full, untaken output register
    assign en = !(is_result && valid_reg && !results.ready);

    always_comb
    begin
        valid_next = valid_reg;
        dist_next  = dist_reg;
        ovf_next   = ovf_reg;
        if (results.ready)
        begin
            valid_next = 1'b0;
        end
        if (is_result && en)
        begin
            valid_next = 1'b1;
            dist_next  = (ext_val > EW'(DIST_MAX)) ? DIST_MAX : ext_val[DIST_W-1:0];
            ovf_next   = tok.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        ovf_reg  <= ovf_next;
    end

    assign results.valid    = valid_reg;
    assign results.distance = dist_reg;
    assign results.overflow = ovf_reg;

endmodule

[rtl/edit_distance_engine.sv]
`timescale 1ns / 1ps
// Levenshtein distance on a row of MAX_LEN cells, one cell per A symbol.
// Throughput: one item (A or B symbol) per cycle unless the chain is stalled;
// B symbols sweep the chain as a wavefront. After the last B item is accepted, the result
// passes through the head register, the cell chain and the output register; a result waiting
// in the output register stalls the chain only when the next result reaches the end.
// Reset clears the control state and cell valid bits at once; no clearing pass.

module edit_distance_engine #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ede_in_if.sink    symbols,
    ede_out_if.source results
);
    import ede_pkg::*;

    localparam int DW = $clog2(MAX_LEN + 1);

    ede_tok_t      tok    [0:MAX_LEN];
    logic [DW-1:0] nv     [0:MAX_LEN];
    logic [DW-1:0] ov     [0:MAX_LEN];
    logic          en;

    ede_head #(
        .MAX_LEN (MAX_LEN),
        .DW      (DW)
    ) u_head (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .symbols (symbols),
        .tok     (tok[0]),
        .new_val (nv[0]),
        .old_val (ov[0])
    );

    for (genvar k = 1; k <= MAX_LEN; k++)
    begin : g_cell
        ede_cell #(
            .MAX_LEN (MAX_LEN),
            .DW      (DW),
            .INDEX   (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .tok_in   (tok[k-1]),
            .left_new (nv[k-1]),
            .left_old (ov[k-1]),
            .tok_out  (tok[k]),
            .out_new  (nv[k]),
            .out_old  (ov[k])
        );
    end

    ede_tail #(
        .MAX_LEN (MAX_LEN),
        .DW      (DW)
    ) u_tail (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok     (tok[MAX_LEN]),
        .new_val (nv[MAX_LEN]),
        .en      (en),
        .results (results)
    );

endmodule
